[rtl/postfix_const_expr_evaluator_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the postfix evaluator core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_CONST_EXPR_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_CONST_EXPR_EVALUATOR_CORE_DEFINES_SVH

// Property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_IMPLIES_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/pcee_pkg.sv]
// ----------------------------------------------------------------------------
// pcee_pkg
// Types, codes and sizes shared by the postfix evaluator core and its units.
// ----------------------------------------------------------------------------
package pcee_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int WORD_W      = 64;
  localparam int NARROW_W    = 32;
  localparam int CNT_W       = $clog2(WORD_W);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;

  // Actions
  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_APPLY  = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // Operators
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_XOR = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW  = 3'd1;
  localparam logic [2:0] ST_MISMATCH   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW   = 3'd3;
  localparam logic [2:0] ST_DIVZERO    = 3'd4;
  localparam logic [2:0] ST_BADTARGET  = 3'd5;

  // Target types
  localparam logic [2:0] TT_CHAR      = 3'd0;
  localparam logic [2:0] TT_SHORT     = 3'd1;
  localparam logic [2:0] TT_INT       = 3'd2;
  localparam logic [2:0] TT_LONG      = 3'd3;
  localparam logic [2:0] TT_LONG_LONG = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TYPE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_UNSIGNED = 2'd1;

  typedef struct packed {
    logic [1:0]               action;
    logic                     is_wide;
    logic [2:0]               operator_code;
    logic signed [WORD_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     result_is_wide;
    logic [2:0]               status;
  } out_item_t;

  typedef struct packed {
    logic              wide;
    logic [WORD_W-1:0] value;
  } ent_t;

  typedef struct packed {
    logic       start;
    logic [2:0] op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_B,
    S_CHK,
    S_EXEC,
    S_FIN_RD,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_SIMPLE,
    A_MUL,
    A_NEG_A,
    A_NEG_B,
    A_DIV,
    A_NEG_Q,
    A_DONE
  } alu_state_t;

endpackage

[rtl/pcee_ram.sv]
// ----------------------------------------------------------------------------
// pcee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pcee_alu.sv]
// ----------------------------------------------------------------------------
// pcee_alu
// Iterative arithmetic unit around one shared 64-bit adder: add, subtract
// and xor in one pass, shift-add multiply and restoring signed divide.
// ----------------------------------------------------------------------------
module pcee_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  pcee_pkg::alu_req_t        req,
  input  logic [pcee_pkg::WORD_W-1:0] a,
  input  logic [pcee_pkg::WORD_W-1:0] b,
  output pcee_pkg::alu_rsp_t        rsp
);
  import pcee_pkg::*;

  alu_state_t        state, state_next;
  logic [2:0]        op;
  logic [WORD_W-1:0] ra, rb, acc, res;
  logic [CNT_W-1:0]  cnt;
  logic              neg_q;
  logic              last;

  logic [WORD_W-1:0] add_x, add_y;
  logic              add_sub;
  logic [WORD_W:0]   sum;
  logic [WORD_W-1:0] rem_shift;

  assign last      = cnt == CNT_W'(WORD_W - 1);
  assign rem_shift = {acc[WORD_W-2:0], ra[WORD_W-1]};
  assign sum       = {1'b0, add_x} + {1'b0, add_y ^ {WORD_W{add_sub}}}
                   + {{WORD_W{1'b0}}, add_sub};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE: begin
        if (req.start) begin
          if (req.op == OP_MUL) begin
            state_next = A_MUL;
          end else if (req.op == OP_DIV) begin
            state_next = A_NEG_A;
          end else begin
            state_next = A_SIMPLE;
          end
        end
      end
      A_SIMPLE: state_next = A_DONE;
      A_MUL:    if (last) state_next = A_DONE;
      A_NEG_A:  state_next = A_NEG_B;
      A_NEG_B:  state_next = A_DIV;
      A_DIV:    if (last) state_next = A_NEG_Q;
      A_NEG_Q:  state_next = A_DONE;
      A_DONE:   state_next = A_IDLE;
      default:  state_next = A_IDLE;
    endcase
  end

  // Adder operand select
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state)
      A_SIMPLE: begin
        add_x   = ra;
        add_y   = rb;
        add_sub = op == OP_SUB;
      end
      A_MUL: begin
        add_x = acc;
        add_y = rb;
      end
      A_NEG_A: begin
        add_y   = ra;
        add_sub = 1'b1;
      end
      A_NEG_B: begin
        add_y   = rb;
        add_sub = 1'b1;
      end
      A_DIV: begin
        add_x   = rem_shift;
        add_y   = rb;
        add_sub = 1'b1;
      end
      A_NEG_Q: begin
        add_y   = ra;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        if (req.start) begin
          op    <= req.op;
          acc   <= '0;
          cnt   <= '0;
          neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
          // multiplier goes in ra so it can shift right
          if (req.op == OP_MUL) begin
            ra <= b;
            rb <= a;
          end else begin
            ra <= a;
            rb <= b;
          end
        end
      end
      A_SIMPLE: begin
        res <= (op == OP_XOR) ? (ra ^ rb) : sum[WORD_W-1:0];
      end
      A_MUL: begin
        if (ra[0]) begin
          acc <= sum[WORD_W-1:0];
        end
        rb  <= {rb[WORD_W-2:0], 1'b0};
        ra  <= {1'b0, ra[WORD_W-1:1]};
        cnt <= cnt + CNT_W'(1);
        if (last) begin
          res <= ra[0] ? sum[WORD_W-1:0] : acc;
        end
      end
      A_NEG_A: begin
        if (ra[WORD_W-1]) begin
          ra <= sum[WORD_W-1:0];
        end
      end
      A_NEG_B: begin
        if (rb[WORD_W-1]) begin
          rb <= sum[WORD_W-1:0];
        end
      end
      A_DIV: begin
        // carry out set means the trial subtract did not borrow
        if (sum[WORD_W]) begin
          acc <= sum[WORD_W-1:0];
        end else begin
          acc <= rem_shift;
        end
        ra  <= {ra[WORD_W-2:0], sum[WORD_W]};
        cnt <= cnt + CNT_W'(1);
      end
      A_NEG_Q: begin
        res <= neg_q ? sum[WORD_W-1:0] : ra;
      end
      default: ;
    endcase
  end

  assign rsp.done   = state == A_DONE;
  assign rsp.result = res;

endmodule

[rtl/postfix_const_expr_evaluator_core.sv]
// ----------------------------------------------------------------------------
// postfix_const_expr_evaluator_core
// Postfix constant-expression evaluator over a stack of tagged 32/64-bit
// values, with a conversion to the configured target type at finish.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per item (push constant, apply operator, finish).
//            in_ready is high only while the sequencer is idle.
//   out_*  : one result per finish request, held in an output register
//            until out_ready takes it.
//   cfg_*  : register writes (target_type, target_unsigned), always ready;
//            write only while the block is idle.
// Path from the accepting edge back to in_ready: push through decode; an
//   operator through decode, two stack reads and execute, where the shared
//   adder in the arithmetic unit steps one bit per cycle for multiply and
//   divide; finish through decode, a read and emit (decode and emit when
//   it only reports an error), with the result valid as in_ready returns.
//   Stack reads go through a registered-read RAM, one operand per cycle.
// Reset clears the stack pointer, the held error and the output valid, and
// loads target_type int, target_unsigned 0. Stack contents are not cleared.
// When the receiver stalls, a finish waits with its result until the output
// register is free; no request is accepted in that time.
// ----------------------------------------------------------------------------
`include "postfix_const_expr_evaluator_core_defines.svh"

module postfix_const_expr_evaluator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pcee_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pcee_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcee_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcee_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pcee_pkg::*;

  function automatic logic [WORD_W-1:0] sext32(input logic [WORD_W-1:0] v);
    return {{(WORD_W - NARROW_W){v[NARROW_W-1]}}, v[NARROW_W-1:0]};
  endfunction

  function automatic logic [WORD_W-1:0] zext32(input logic [WORD_W-1:0] v);
    return {{(WORD_W - NARROW_W){1'b0}}, v[NARROW_W-1:0]};
  endfunction

  state_t            state, state_next;
  in_item_t          item;
  logic [SP_W-1:0]   sp, sp_next, sp_m1, sp_m2;
  logic [2:0]        held_error, held_error_next;
  ent_t              b_ent, b_ent_next;
  ent_t              rd_ent, wr_ent;
  out_item_t         pend, pend_next;
  logic [2:0]        target_type;
  logic              target_unsigned;

  logic              ram_we;
  logic [STACK_AW-1:0] ram_waddr, ram_raddr;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [WORD_W-1:0] alu_a, alu_b, alu_res;

  logic              bad_target, apply_go, fin_direct, mismatch, div_zero;
  logic              slot_free, emit_load;
  logic [WORD_W-1:0] fin_val;
  logic              fin_wide;

  assign cfg_ready = 1'b1;

  assign sp_m1     = sp - SP_W'(1);
  assign sp_m2     = sp - SP_W'(2);
  assign ram_raddr = (state == S_RD_B) ? sp_m2[STACK_AW-1:0] : sp_m1[STACK_AW-1:0];

  assign bad_target = (target_type < TT_INT) || (target_type > TT_LONG_LONG);
  assign apply_go   = (held_error == ST_OK) && (item.operator_code <= OP_XOR)
                    && (sp >= SP_W'(2));
  assign fin_direct = (held_error != ST_OK) || (sp == '0) || bad_target;
  assign mismatch   = (b_ent.wide != item.is_wide) || (rd_ent.wide != item.is_wide);
  assign div_zero   = (item.operator_code == OP_DIV) &&
                      (item.is_wide ? (b_ent.value == '0)
                                    : (b_ent.value[NARROW_W-1:0] == '0));
  assign slot_free  = !out_valid || out_ready;

  assign alu_a   = item.is_wide ? rd_ent.value : sext32(rd_ent.value);
  assign alu_b   = item.is_wide ? b_ent.value : sext32(b_ent.value);
  assign alu_res = item.is_wide ? alu_rsp.result : zext32(alu_rsp.result);

  // Conversion of the top entry at finish
  always_comb begin
    fin_val  = sext32(rd_ent.value);
    fin_wide = 1'b0;
    if (target_type == TT_LONG_LONG) begin
      fin_wide = 1'b1;
      if (rd_ent.wide) begin
        fin_val = rd_ent.value;
      end else if (target_unsigned) begin
        fin_val = zext32(rd_ent.value);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (item.action)
          ACT_APPLY:  state_next = apply_go ? S_RD_B : S_IDLE;
          ACT_FINISH: state_next = fin_direct ? S_EMIT : S_FIN_RD;
          default:    state_next = S_IDLE;
        endcase
      end
      S_RD_B:   state_next = S_CHK;
      S_CHK:    state_next = (mismatch || div_zero) ? S_IDLE : S_EXEC;
      S_EXEC:   if (alu_rsp.done) state_next = S_IDLE;
      S_FIN_RD: state_next = S_EMIT;
      S_EMIT:   if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = sp[STACK_AW-1:0];
    wr_ent          = '0;
    alu_req         = '0;
    sp_next         = sp;
    held_error_next = held_error;
    b_ent_next      = b_ent;
    pend_next       = pend;
    emit_load       = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_DECODE: begin
        unique case (item.action)
          ACT_PUSH: begin
            if (held_error == ST_OK) begin
              if (sp == SP_W'(STACK_DEPTH)) begin
                held_error_next = ST_OVERFLOW;
              end else begin
                ram_we       = 1'b1;
                wr_ent.wide  = item.is_wide;
                wr_ent.value = item.is_wide ? item.operand_value
                                            : zext32(item.operand_value);
                sp_next      = sp + SP_W'(1);
              end
            end
          end
          ACT_APPLY: begin
            if ((held_error == ST_OK) && (item.operator_code <= OP_XOR) &&
                (sp < SP_W'(2))) begin
              held_error_next = ST_UNDERFLOW;
            end
          end
          ACT_FINISH: begin
            pend_next = '0;
            if (held_error != ST_OK) begin
              pend_next.status = held_error;
            end else if (sp == '0) begin
              pend_next.status = ST_UNDERFLOW;
            end else if (bad_target) begin
              pend_next.status = ST_BADTARGET;
            end
          end
          default: ;
        endcase
      end
      S_RD_B: b_ent_next = rd_ent;
      S_CHK: begin
        if (mismatch) begin
          held_error_next = ST_MISMATCH;
        end else if (div_zero) begin
          held_error_next = ST_DIVZERO;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = item.operator_code;
        end
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          ram_we       = 1'b1;
          ram_waddr    = sp_m2[STACK_AW-1:0];
          wr_ent.wide  = item.is_wide;
          wr_ent.value = alu_res;
          sp_next      = sp_m1;
        end
      end
      S_FIN_RD: begin
        pend_next.result_value   = fin_val;
        pend_next.result_is_wide = fin_wide;
        pend_next.status         = ST_OK;
      end
      S_EMIT: begin
        if (slot_free) begin
          emit_load       = 1'b1;
          sp_next         = '0;
          held_error_next = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      sp              <= '0;
      held_error      <= ST_OK;
      out_valid       <= 1'b0;
      target_type     <= TT_INT;
      target_unsigned <= 1'b0;
    end else begin
      state      <= state_next;
      sp         <= sp_next;
      held_error <= held_error_next;
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TARGET_TYPE:     target_type     <= cfg_data[2:0];
          REG_TARGET_UNSIGNED: target_unsigned <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
    b_ent <= b_ent_next;
    pend  <= pend_next;
    if (emit_load) begin
      out_item <= pend;
    end
  end

  pcee_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (ram_raddr),
    .rdata (rd_ent)
  );

  pcee_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (alu_a),
    .b   (alu_b),
    .rsp (alu_rsp)
  );

  `ASSERT_ALWAYS(a_sp_range, sp <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `ASSERT_IMPLIES(a_alu_owner, alu_rsp.done, state == S_EXEC, "alu done outside execute")
  `ASSERT_IMPLIES_NEXT(a_pop_on_done, alu_rsp.done, sp == $past(sp) - SP_W'(1), "no pop on done")
  `ASSERT_IMPLIES(a_emit_origin, $rose(out_valid), $past(state) == S_EMIT, "result outside emit")
  `ASSERT_IMPLIES_NEXT(a_clear_on_emit, emit_load, sp == '0 && held_error == ST_OK, "not cleared")

endmodule
